// ----- design/fdl_pkg.sv -----
package fdl_pkg;

    localparam int DELAY_DEPTH = 2048;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int LEN_W       = $clog2(DELAY_DEPTH + 1);

    localparam int SAMPLE_W = 16;
    localparam int DLEN_W   = 11;
    localparam int GAIN_W   = 15;
    localparam int CFG_W    = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [DLEN_W-1:0] DLEN_RESET = 11'd1000;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd16384;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_GAIN      = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FB,
        S_SUM,
        S_MIX
    } t_state;

    typedef struct packed {
        logic load;
        logic fb;
        logic sum;
        logic mix;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    // q0.15 gain, round half up: (a * g + 2^14) >>> 15
    function automatic t_sample gain_q15(input t_sample a, input logic [GAIN_W-1:0] g);
        logic signed [31:0] p;
        logic signed [31:0] s;
        p = 32'(a) * 32'($signed({1'b0, g}));
        s = p + 32'sd16384;
        return s[30:15];
    endfunction

endpackage

// ----- design/fdl_in_if.sv -----
interface fdl_in_if;
    import fdl_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

// ----- design/fdl_out_if.sv -----
interface fdl_out_if;
    import fdl_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

// ----- design/fdl_ctrl.sv -----
module fdl_ctrl
    import fdl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FB;
                end
            end
            S_FB: begin
                o_cmd.fb = 1'b1;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_MIX;
            end
            S_MIX: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.mix = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/fdl_datapath.sv -----
module fdl_datapath
    import fdl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_sample              i_sample_in,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output t_sample              o_sample_out
);

    logic [DLEN_W-1:0] r_delay_length;
    logic [GAIN_W-1:0] r_feedback_gain;
    logic [GAIN_W-1:0] r_mix_gain;

    logic [ADDR_W-1:0] r_pos;
    logic [LEN_W-1:0]  r_fill;
    logic [ADDR_W-1:0] r_addr;

    t_sample r_mem [DELAY_DEPTH];
    t_sample r_rd_data;
    logic    r_rd_ok;
    t_sample r_dry;
    t_sample r_wet;
    t_sample r_sum;
    t_sample r_out;
    logic    r_out_valid;

    logic [LEN_W-1:0]  len_eff;
    logic [ADDR_W-1:0] pos_eff;
    logic [LEN_W-1:0]  pos_inc;
    t_sample           rd_masked;
    t_sample           wet;
    logic signed [SAMPLE_W:0] sum_wide;
    t_sample           sum_sat;
    t_sample           res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length  <= DLEN_RESET;
            r_feedback_gain <= GAIN_RESET;
            r_mix_gain      <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DELAY_LENGTH:  r_delay_length  <= i_cfg_data[DLEN_W-1:0];
                CFG_FEEDBACK_GAIN: r_feedback_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_MIX_GAIN:      r_mix_gain      <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective ring length: zero acts as one, saturate at memory depth
    always_comb begin
        if (r_delay_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(r_delay_length) > 32'(DELAY_DEPTH)) begin
            len_eff = LEN_W'(DELAY_DEPTH);
        end else begin
            len_eff = LEN_W'(r_delay_length);
        end
    end

    assign pos_eff = (LEN_W'(r_pos) >= len_eff) ? '0 : r_pos;
    assign pos_inc = LEN_W'(r_addr) + LEN_W'(1);

    assign rd_masked = r_rd_ok ? r_rd_data : '0;
    assign wet       = gain_q15(rd_masked, r_feedback_gain);
    assign sum_wide  = (SAMPLE_W+1)'(r_dry) + (SAMPLE_W+1)'(r_wet);

    always_comb begin
        if (sum_wide > 17'sd32767) begin
            sum_sat = 16'sh7fff;
        end else if (sum_wide < -17'sd32768) begin
            sum_sat = 16'sh8000;
        end else begin
            sum_sat = sum_wide[SAMPLE_W-1:0];
        end
    end

    assign res = gain_q15(r_sum, r_mix_gain);

    // entries are written in ascending order from zero, so the written set
    // is always a prefix: anything at or above the fill count reads as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_data <= r_mem[pos_eff];
        end
        if (i_cmd.mix) begin
            r_mem[r_addr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr  <= pos_eff;
            r_rd_ok <= LEN_W'(pos_eff) < r_fill;
            r_dry   <= i_sample_in;
        end
        if (i_cmd.fb) begin
            r_wet <= wet;
        end
        if (i_cmd.sum) begin
            r_sum <= sum_sat;
        end
        if (i_cmd.mix) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.mix) begin
                r_pos <= (pos_inc >= len_eff) ? '0 : pos_inc[ADDR_W-1:0];
                if (pos_inc > r_fill) begin
                    r_fill <= pos_inc;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_sample_out   = r_out;

endmodule

// ----- design/feedback_delay_line.sv -----
// feedback comb delay on signed q1.15 audio. each accepted sample reads the
// ring entry at the write position, scales it by feedback_gain, adds the dry
// sample with clamping to full scale, scales by mix_gain, emits the result
// and writes it back to the same entry before advancing the position modulo
// delay_length. each sample passes in turn through memory read, feedback multiply,
// add and clamp, and mix multiply with write-back, sequenced by fdl_ctrl; the
// next sample is taken on the cycle after write-back, also while the result
// still waits in the output register. a new result only stalls the block if
// the previous one has not yet been taken. the delay memory is not swept at
// reset: a fill count marks the written prefix and entries above it read as
// zero, so the block is ready right after reset. configuration goes through
// a plain write port (index 0 delay_length, 1 feedback_gain, 2 mix_gain)
// and must only be written while the block is idle.
module feedback_delay_line
    import fdl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    fdl_in_if.sink               i_in,
    fdl_out_if.source            o_out
);

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    // sequencer: idle, feedback multiply, sum and clamp, mix and write-back
    fdl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // config registers, ring memory, arithmetic and output register
    fdl_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_in.sample_in),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_sample_out (o_out.sample_out)
    );

    // input transaction is taken only in the idle state
    assign i_in.ready = in_ready;

endmodule

// ----- design/fdl_chk.sv -----
module fdl_chk
    import fdl_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_sample i_sample_out
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sample_out))
        else $error("stalled output changed");

    // no transaction in the cycle after one was taken
    a_busy_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input ready right after a transaction");

    // still busy after the feedback and sum states, in the write-back state
    a_busy_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##3 !i_in_ready)
        else $error("input ready before write-back");

    // a new result only appears after a busy cycle
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result without a processing cycle");

endmodule

bind feedback_delay_line fdl_chk u_fdl_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_sample_out (o_out.sample_out)
);

// ----- dv/tb_feedback_delay_line.sv -----
`timescale 1ns / 1ps

module tb_feedback_delay_line
    import fdl_pkg::*;
();

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 1330;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int CYCLE_LIMIT   = 1000000;

    // index 3 is not decoded by the block, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum bit {
        ROW_CFG,
        ROW_SMP
    } t_row_kind;

    // one row of the directed table: a register write or a sample, with the
    // expected output typed in only where it is obvious
    typedef struct {
        t_row_kind           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        t_sample              smp;
        bit                   typed;
        t_sample              want;
    } t_row;

    localparam int N_ROWS = 31;

    const t_row DIR_ROWS [N_ROWS] = '{
        // reset settings, empty memory: output is half the input, rounded up
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, 0, 1'b1, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, 32767, 1'b1, 16384},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, -32768, 1'b1, -16384},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, 1, 1'b1, 1},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, -1, 1'b1, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, -2, 1'b1, -1},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, 16'h5555, 1'b0, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, 16'hAAAA, 1'b0, 0},
        // full gains, then shrink the ring below the write position
        '{ROW_CFG, CFG_MIX_GAIN, 32767, 0, 1'b0, 0},
        '{ROW_CFG, CFG_FEEDBACK_GAIN, 32767, 0, 1'b0, 0},
        '{ROW_CFG, CFG_DELAY_LENGTH, 5, 0, 1'b0, 0},
        // old contents come back, sums clamp at both rails
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, 32767, 1'b0, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, 32767, 1'b0, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, -32768, 1'b0, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, -32768, 1'b0, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, 12345, 1'b0, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, 32767, 1'b0, 0},
        // zero length behaves as a one-sample ring
        '{ROW_CFG, CFG_DELAY_LENGTH, 0, 0, 1'b0, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, 20000, 1'b0, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, 20000, 1'b0, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, -20000, 1'b0, 0},
        // mix gain zero silences the output
        '{ROW_CFG, CFG_MIX_GAIN, 0, 0, 1'b0, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, 32767, 1'b1, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, -32768, 1'b1, 0},
        // no feedback, full mix, all-ones data on length and unused index
        '{ROW_CFG, CFG_FEEDBACK_GAIN, 0, 0, 1'b0, 0},
        '{ROW_CFG, CFG_MIX_GAIN, 32767, 0, 1'b0, 0},
        '{ROW_CFG, CFG_DELAY_LENGTH, 15'h7FFF, 0, 1'b0, 0},
        '{ROW_CFG, CFG_UNUSED, 15'h7FFF, 0, 1'b0, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, 32767, 1'b0, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, -32768, 1'b0, 0},
        '{ROW_SMP, CFG_DELAY_LENGTH, 0, 16'h0F0F, 1'b0, 0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    fdl_in_if  in_ch ();
    fdl_out_if out_ch ();

    feedback_delay_line dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // own copy of the comb state and register file
    t_sample           ring_mem [DELAY_DEPTH];
    int unsigned       ring_pos;
    logic [DLEN_W-1:0] cfg_len;
    logic [GAIN_W-1:0] cfg_fb;
    logic [GAIN_W-1:0] cfg_mix;

    // outputs still owed by the block, oldest first
    t_sample pending_out [$];

    int  err_cnt   = 0;
    int  cyc_cnt   = 0;
    bit  src_idle  = 1'b1;
    bit  snk_idle  = 1'b1;
    bit  hold_req  = 1'b0;
    bit  hold_done = 1'b0;
    int  snk_wait  = 0;

    // q1.15 scale, round to nearest with ties going up
    function automatic int scale_q15(input int a, input int g);
        longint p;
        p = longint'(a) * longint'(g) + 64'sd16384;
        return int'(p >>> 15);
    endfunction

    // one step of the feedback comb: returns the output and updates the ring
    function automatic t_sample comb_output(input t_sample dry);
        int unsigned len;
        int unsigned pos;
        int          wet;
        int          acc;
        t_sample     res;
        len = (cfg_len == 0) ? 1 : int'(cfg_len);
        if (len > DELAY_DEPTH) begin
            len = DELAY_DEPTH;
        end
        // a ring shortened under the write position restarts at entry zero
        pos = (ring_pos >= len) ? 0 : ring_pos;
        wet = scale_q15(int'(ring_mem[pos]), int'(cfg_fb));
        acc = int'(dry) + wet;
        if (acc > 32767) begin
            acc = 32767;
        end else if (acc < -32768) begin
            acc = -32768;
        end
        res = t_sample'(scale_q15(acc, int'(cfg_mix)));
        ring_mem[pos] = res;
        pos = pos + 1;
        ring_pos = (pos >= len) ? 0 : pos;
        return res;
    endfunction

    function automatic void cfg_update(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] data);
        case (idx)
            CFG_DELAY_LENGTH:  cfg_len = data[DLEN_W-1:0];
            CFG_FEEDBACK_GAIN: cfg_fb  = data[GAIN_W-1:0];
            CFG_MIX_GAIN:      cfg_mix = data[GAIN_W-1:0];
            default: ;
        endcase
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_sample rand_sample();
        int r;
        r = $urandom_range(0, 11);
        case (r)
            0:       return t_sample'(16'h7FFF);
            1:       return t_sample'(16'h8000);
            2:       return t_sample'(int'($urandom_range(0, 511)) - 256);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // offer one sample, wait for the transaction, record what should come out
    task automatic send_sample(input t_sample smp, input bit typed, input t_sample want);
        int      gap;
        t_sample pred;
        gap = src_idle ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid     <= 1'b0;
            in_ch.sample_in <= t_sample'($urandom);
        end
        @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= smp;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        pred = comb_output(smp);
        pending_out.push_back(typed ? want : pred);
    endtask

    task automatic src_stop();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_out.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // registers move only while the block is idle
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        cfg_update(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] rand_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            return '0;
        end else if (r < 27) begin
            return 15'h7FFF;
        end else if (r < 45) begin
            return CFG_W'($urandom_range(24000, 32767));
        end
        return CFG_W'($urandom);
    endfunction

    // lengths: mostly short rings so feedback recirculates, plus the extremes;
    // upper data bits above the length field are random
    function automatic logic [CFG_W-1:0] rand_len();
        int                r;
        logic [DLEN_W-1:0] len;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            len = DLEN_W'($urandom_range(0, 1));
        end else if (r < 10) begin
            len = 11'd10;
        end else if (r < 14) begin
            len = 11'd2000;
        end else if (r < 17) begin
            len = 11'd2047;
        end else if (r < 25) begin
            len = DLEN_W'($urandom_range(1, 2047));
        end else begin
            len = DLEN_W'($urandom_range(2, 40));
        end
        return {(CFG_W-DLEN_W)'($urandom), len};
    endfunction

    task automatic cfg_shuffle();
        if ($urandom_range(0, 1)) begin
            cfg_write(CFG_DELAY_LENGTH, rand_len());
        end
        if ($urandom_range(0, 1)) begin
            cfg_write(CFG_FEEDBACK_GAIN, rand_gain());
        end
        if ($urandom_range(0, 1)) begin
            cfg_write(CFG_MIX_GAIN, rand_gain());
        end
        if ($urandom_range(0, 7) == 0) begin
            cfg_write(CFG_UNUSED, CFG_W'($urandom));
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (snk_wait > 0) begin
            snk_wait--;
            out_ch.ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            snk_wait  = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else if (snk_idle && $urandom_range(0, 3) == 0) begin
            snk_wait = pick_gap();
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // output checker: every transaction must match the oldest expectation
    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_out.size() == 0) begin
                $error("sample_out: unexpected transaction, got %0d", out_ch.sample_out);
                err_cnt++;
            end else begin
                want = pending_out.pop_front();
                if (out_ch.sample_out !== want) begin
                    $error("sample_out: expected %0d, got %0d", want, out_ch.sample_out);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int rnd_done;
        int phase;
        int n;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_DELAY_LENGTH;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.sample_in = '0;

        // predictor starts from the reset state
        cfg_len  = DLEN_RESET;
        cfg_fb   = GAIN_RESET;
        cfg_mix  = GAIN_RESET;
        ring_pos = 0;
        foreach (ring_mem[i]) begin
            ring_mem[i] = '0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].kind == ROW_CFG) begin
                src_stop();
                wait_idle();
                cfg_write(DIR_ROWS[i].idx, DIR_ROWS[i].data);
            end else begin
                send_sample(DIR_ROWS[i].smp, DIR_ROWS[i].typed, DIR_ROWS[i].want);
            end
        end

        // random phases, each with its own register setting and idle pattern
        rnd_done = 0;
        phase    = 0;
        while (rnd_done < RANDOM_ITEMS) begin
            n = $urandom_range(20, 120);
            src_stop();
            wait_idle();
            cfg_shuffle();
            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            if (phase == 0) begin
                // back-to-back samples against a stalled receiver fill the block
                src_idle = 1'b0;
                hold_req = 1'b1;
            end
            for (int k = 0; k < n; k++) begin
                if (phase == 1 && k == n / 2) begin
                    // sender pause until everything in flight is out
                    src_stop();
                    wait_drained();
                end
                send_sample(rand_sample(), 1'b0, '0);
            end
            rnd_done += n;
            phase++;
        end

        src_stop();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/fdl_pkg.sv
design/fdl_in_if.sv
design/fdl_out_if.sv
design/fdl_ctrl.sv
design/fdl_datapath.sv
design/feedback_delay_line.sv
design/fdl_chk.sv
dv/tb_feedback_delay_line.sv
